[hw/rtl/wpm_pkg.sv]
// shared types and constants for the wildcard pattern matcher
package wpm_pkg;

	// default pattern capacity in bytes
	localparam int MAX_PATTERN = 32;

	// wildcard symbols in the pattern
	localparam logic [7:0] SYM_STAR = 8'd42;
	localparam logic [7:0] SYM_ANY  = 8'd63;

	// request commands
	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_TEXT   = 2'd1,
		CMD_END    = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// per-cell control from the top level
	typedef struct packed {
		logic advance;  // a text byte updates the match bit
		logic restart;  // the match bit reloads with the all-star prefix
		logic clear;    // the cell drops its pattern byte
		logic load;     // the cell takes the appended pattern byte
	} cell_ctrl_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic next_bit; // new match bit of the previous prefix
		logic row_bit;  // current match bit of the previous prefix
		logic all_star; // every pattern byte so far is a star
		logic result;   // match bit of the longest valid prefix so far
	} cell_link_t;

endpackage

[hw/rtl/wpm_req_if.sv]
// request channel carrying command and symbol
interface wpm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] symbol;

	modport source (output valid, output cmd, output symbol, input ready);
	modport sink (input valid, input cmd, input symbol, output ready);
endinterface

[hw/rtl/wpm_res_if.sv]
// result channel carrying the match verdict
interface wpm_res_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

[hw/rtl/wpm_cell.sv]
// one pattern position: stored byte, valid bit and match bit
module wpm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wpm_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          symbol,
	input  wpm_pkg::cell_link_t link_in,
	output wpm_pkg::cell_link_t link_out
);

	logic [7:0] pat_q;
	logic       valid_q;
	logic       match_q;
	logic       is_star;
	logic       hits;
	logic       next_bit;
	logic       eff_valid;
	logic       eff_star;
	logic       all_star;

	// stored byte decode
	assign is_star = (pat_q == wpm_pkg::SYM_STAR);
	assign hits    = (pat_q == wpm_pkg::SYM_ANY) || (pat_q == symbol);

	// row update for one text byte
	always_comb begin
		next_bit = 1'b0;
		if (valid_q) begin
			if (is_star) begin
				next_bit = link_in.next_bit | match_q;
			end else if (hits) begin
				next_bit = link_in.row_bit;
			end
		end
	end

	// restart value seen through the pattern as it stands after this request
	assign eff_valid = ctrl.load | (valid_q & ~ctrl.clear);
	assign eff_star  = ctrl.load ? (symbol == wpm_pkg::SYM_STAR) : is_star;
	assign all_star  = link_in.all_star & eff_valid & eff_star;

	// hand-off to the next cell
	always_comb begin
		link_out.next_bit = next_bit;
		link_out.row_bit  = match_q;
		link_out.all_star = all_star;
		link_out.result   = valid_q ? match_q : link_in.result;
	end

	// pattern byte, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pat_q <= symbol;
		end
	end

	// valid and match bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (ctrl.load) begin
				valid_q <= 1'b1;
			end
			if (ctrl.advance) begin
				match_q <= next_bit;
			end else if (ctrl.restart) begin
				match_q <= all_star;
			end
		end
	end

endmodule

[hw/rtl/wildcard_pattern_matcher.sv]
// top level of the wildcard pattern matcher: control, cell chain and result register
// One request is taken every clock cycle; requests stall only while a finished
// result waits to be taken. Each cell holds one pattern byte and its match bit,
// so a text byte updates the whole row at once; the cycle time is set
// by the star carry and the all-star restart prefix, which ripple through all
// MAX_PATTERN cells. An end-of-text request yields its result in the output
// register in the cycle after it is accepted. Pattern bytes beyond MAX_PATTERN
// are dropped and flagged in pattern_overflow until the next clear.
module wildcard_pattern_matcher #(
	parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN
) (
	input logic       clk,
	input logic       arst_n,
	wpm_req_if.sink   requests,
	wpm_res_if.source results
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [LW-1:0]        len_q;
	logic                 ovf_q;
	logic                 row0_q;
	logic                 res_valid_q;
	logic                 res_matched_q;
	logic                 res_ovf_q;
	logic                 accept;
	logic                 full;
	wpm_pkg::cmd_t        cmd;
	wpm_pkg::cell_ctrl_t  ctrl [MAX_PATTERN];
	wpm_pkg::cell_link_t  links [MAX_PATTERN + 1];

	// request handshake
	assign requests.ready = ~res_valid_q | results.ready;
	assign accept         = requests.valid & requests.ready;
	assign cmd            = wpm_pkg::cmd_t'(requests.cmd);
	assign full           = (len_q == LW'(MAX_PATTERN));

	// head of the chain is the empty prefix
	always_comb begin
		links[0].next_bit = 1'b0;
		links[0].row_bit  = row0_q;
		links[0].all_star = 1'b1;
		links[0].result   = row0_q;
	end

	// cell chain
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		always_comb begin
			ctrl[i].advance = accept && (cmd == wpm_pkg::CMD_TEXT);
			ctrl[i].restart = accept && (cmd != wpm_pkg::CMD_TEXT);
			ctrl[i].clear   = accept && (cmd == wpm_pkg::CMD_CLEAR);
			ctrl[i].load    = accept && (cmd == wpm_pkg::CMD_APPEND) && !full
				&& (len_q == LW'(i));
		end

		wpm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[i]),
			.symbol   (requests.symbol),
			.link_in  (links[i]),
			.link_out (links[i + 1])
		);
	end

	// pattern length, overflow flag and empty-prefix match bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			row0_q <= 1'b1;
		end else if (accept) begin
			case (cmd)
				wpm_pkg::CMD_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + 1'b1;
					end
					row0_q <= 1'b1;
				end
				wpm_pkg::CMD_TEXT: begin
					row0_q <= 1'b0;
				end
				wpm_pkg::CMD_CLEAR: begin
					len_q  <= '0;
					ovf_q  <= 1'b0;
					row0_q <= 1'b1;
				end
				default: begin
					row0_q <= 1'b1;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && (cmd == wpm_pkg::CMD_END)) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == wpm_pkg::CMD_END)) begin
			res_matched_q <= links[MAX_PATTERN].result;
			res_ovf_q     <= ovf_q;
		end
	end

	assign results.valid            = res_valid_q;
	assign results.matched          = res_matched_q;
	assign results.pattern_overflow = res_ovf_q;

	// a new result only follows an end-of-text request
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(accept && (cmd == wpm_pkg::CMD_END)))
		else $error("result appeared without end-of-text request");

	// the pattern length stays within capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	// a clear empties the pattern and drops the overflow flag
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == wpm_pkg::CMD_CLEAR) |=> (len_q == '0) && !ovf_q)
		else $error("clear did not empty the pattern");

	// a waiting result is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !results.ready |=> res_valid_q && $stable(res_matched_q))
		else $error("pending result lost");

endmodule

[sim/tb_wildcard_pattern_matcher.sv]
// testbench for the wildcard pattern matcher: glob row prediction and result checking
module tb_wildcard_pattern_matcher;
	timeunit 1ns;
	timeprecision 1ps;

	// request count at which the random phase stops, directed tests included
	localparam int TOTAL_ITEMS = 850;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic clk;
	logic arst_n;

	wpm_req_if req_ch();
	wpm_res_if res_ch();

	wildcard_pattern_matcher dut (
		.clk,
		.arst_n,
		.requests(req_ch),
		.results(res_ch)
	);

	// predicted state of the matcher
	logic [7:0]                    pattern_mem[wpm_pkg::MAX_PATTERN];
	int                            pattern_len;
	logic [wpm_pkg::MAX_PATTERN:0] prefix_row;
	logic                          overflow_seen;

	// verdicts still owed by the block, oldest first
	verdict_t pending_verdicts[$];

	// stimulus bookkeeping
	logic [7:0] plan_pattern[$];
	logic [7:0] text_buf[$];
	bit         quiet_sender;
	int         items_sent;
	int         errors;
	int         sink_hold;
	int         sink_quiet;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	// reload the row with the all-star prefix of the pattern
	function automatic void reload_row();
		logic all_star;
		all_star = 1'b1;
		prefix_row = '0;
		prefix_row[0] = 1'b1;
		for (int j = 1; j <= pattern_len; j++) begin
			if (pattern_mem[j-1] != wpm_pkg::SYM_STAR)
				all_star = 1'b0;
			prefix_row[j] = all_star;
		end
	endfunction

	// advance the row by one text byte; a pattern star stays a wildcard for any byte
	function automatic void step_row(logic [7:0] c);
		logic [wpm_pkg::MAX_PATTERN:0] nxt;
		nxt = '0;
		for (int j = 1; j <= pattern_len; j++) begin
			if (pattern_mem[j-1] == wpm_pkg::SYM_STAR)
				nxt[j] = nxt[j-1] | prefix_row[j];
			else if (pattern_mem[j-1] == wpm_pkg::SYM_ANY || pattern_mem[j-1] == c)
				nxt[j] = prefix_row[j-1];
			else
				nxt[j] = 1'b0;
		end
		prefix_row = nxt;
	endfunction

	// apply one accepted request to the predicted state
	function automatic void predict_request(wpm_pkg::cmd_t cmd, logic [7:0] sym);
		verdict_t v;
		case (cmd)
			wpm_pkg::CMD_APPEND: begin
				if (pattern_len < wpm_pkg::MAX_PATTERN) begin
					pattern_mem[pattern_len] = sym;
					pattern_len++;
				end else begin
					overflow_seen = 1'b1;
				end
				reload_row();
			end
			wpm_pkg::CMD_TEXT: begin
				step_row(sym);
			end
			wpm_pkg::CMD_END: begin
				v.matched = prefix_row[pattern_len];
				v.overflow = overflow_seen;
				pending_verdicts.push_back(v);
				reload_row();
			end
			default: begin
				pattern_len = 0;
				overflow_seen = 1'b0;
				reload_row();
			end
		endcase
	endfunction

	// sender gap after a request
	function automatic int pick_gap();
		int r;
		if (quiet_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// byte from a small alphabet, with wildcards at the given percentage
	function automatic logic [7:0] pick_symbol(int wild_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < wild_pct / 2)
			return wpm_pkg::SYM_STAR;
		if (r < wild_pct)
			return wpm_pkg::SYM_ANY;
		if (r < 85)
			return 8'h61 + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	// build a text that fits the planned pattern, optionally spoiled by one edit
	function automatic void make_text(bit mutate);
		int lim;
		int pos;
		text_buf.delete();
		lim = (plan_pattern.size() < wpm_pkg::MAX_PATTERN) ? plan_pattern.size() :
			wpm_pkg::MAX_PATTERN;
		for (int i = 0; i < lim; i++) begin
			if (plan_pattern[i] == wpm_pkg::SYM_STAR)
				repeat ($urandom_range(0, 3)) text_buf.push_back(pick_symbol(10));
			else if (plan_pattern[i] == wpm_pkg::SYM_ANY)
				text_buf.push_back(pick_symbol(10));
			else
				text_buf.push_back(plan_pattern[i]);
		end
		if (mutate) begin
			pos = (text_buf.size() > 0) ? $urandom_range(0, text_buf.size() - 1) : 0;
			case ($urandom_range(0, 2))
				0: if (text_buf.size() > 0) text_buf[pos] = pick_symbol(10);
				1: if (text_buf.size() > 0) text_buf.delete(pos);
				default: text_buf.push_back(pick_symbol(10));
			endcase
		end
	endfunction

	// send one request, then idle for a random gap
	task automatic send_request(input wpm_pkg::cmd_t cmd, input logic [7:0] sym);
		int gap;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.symbol <= sym;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_request(cmd, sym);
		items_sent++;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			req_ch.cmd <= wpm_pkg::cmd_t'($urandom_range(0, 3));
			req_ch.symbol <= 8'($urandom_range(0, 255));
		end
	endtask

	// hold off requests until every verdict has come back
	task automatic wait_for_verdicts();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// text bytes from the buffer, with or without the closing end-of-text
	task automatic send_text(bit mutate, bit close);
		make_text(mutate);
		foreach (text_buf[i]) send_request(wpm_pkg::CMD_TEXT, text_buf[i]);
		if (close)
			send_request(wpm_pkg::CMD_END, 8'($urandom_range(0, 255)));
	endtask

	// empty pattern matches only the empty text
	task automatic test_empty_pattern();
		send_request(wpm_pkg::CMD_END, 8'h00);
		send_request(wpm_pkg::CMD_TEXT, 8'h00);
		send_request(wpm_pkg::CMD_END, 8'hFF);
		send_request(wpm_pkg::CMD_CLEAR, 8'hFF);
		send_request(wpm_pkg::CMD_END, 8'h00);
	endtask

	// literal bytes at the extremes and the single-byte wildcard
	task automatic test_literals_and_any();
		send_request(wpm_pkg::CMD_APPEND, 8'h00);
		send_request(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_ANY);
		send_request(wpm_pkg::CMD_APPEND, 8'hFF);
		send_request(wpm_pkg::CMD_TEXT, 8'h00);
		send_request(wpm_pkg::CMD_TEXT, 8'h78);
		send_request(wpm_pkg::CMD_TEXT, 8'hFF);
		send_request(wpm_pkg::CMD_END, 8'h00);
		send_request(wpm_pkg::CMD_TEXT, 8'h00);
		send_request(wpm_pkg::CMD_TEXT, 8'hFF);
		send_request(wpm_pkg::CMD_END, 8'hFF);
	endtask

	// star matching empty runs, a text star, and restart after an append
	task automatic test_star_against_star();
		send_request(wpm_pkg::CMD_CLEAR, 8'h00);
		send_request(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
		send_request(wpm_pkg::CMD_END, 8'h00);
		send_request(wpm_pkg::CMD_APPEND, 8'h61);
		send_request(wpm_pkg::CMD_END, 8'h00);
		send_request(wpm_pkg::CMD_TEXT, wpm_pkg::SYM_STAR);
		send_request(wpm_pkg::CMD_TEXT, 8'h61);
		send_request(wpm_pkg::CMD_END, 8'h00);
		send_request(wpm_pkg::CMD_TEXT, wpm_pkg::SYM_STAR);
		send_request(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
		send_request(wpm_pkg::CMD_END, 8'h00);
	endtask

	// patterns filled to just below, at and past capacity, then cleared
	task automatic test_full_pattern();
		int n;
		repeat (4) begin
			send_request(wpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
			plan_pattern.delete();
			n = $urandom_range(wpm_pkg::MAX_PATTERN - 1, wpm_pkg::MAX_PATTERN + 3);
			repeat (n) begin
				plan_pattern.push_back(pick_symbol(40));
				send_request(wpm_pkg::CMD_APPEND, plan_pattern[$]);
			end
			send_text(1'b0, 1'b1);
			send_text($urandom_range(0, 1), 1'b1);
		end
		send_request(wpm_pkg::CMD_CLEAR, 8'h00);
		send_request(wpm_pkg::CMD_END, 8'h00);
		wait_for_verdicts();
	endtask

	// mostly well-formed pattern and text sequences, some noise and broken texts
	task automatic test_random_sequences();
		int plen;
		int r;
		bit need_clear;
		need_clear = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			quiet_sender = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_request(wpm_pkg::cmd_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
				need_clear = 1'b1;
			end else begin
				if (need_clear || $urandom_range(0, 3) != 0) begin
					send_request(wpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
					plan_pattern.delete();
				end
				need_clear = 1'b0;
				r = $urandom_range(0, 99);
				plen = (r < 85) ? $urandom_range(0, 6) :
				       (r < 95) ? $urandom_range(7, 16) : $urandom_range(28, 34);
				repeat (plen) begin
					plan_pattern.push_back(pick_symbol(40));
					send_request(wpm_pkg::CMD_APPEND, plan_pattern[$]);
				end
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 7) == 0)
						send_text($urandom_range(0, 1), 1'b0);
					else
						send_text($urandom_range(0, 3) == 0, 1'b1);
				end
				if ($urandom_range(0, 11) == 0)
					wait_for_verdicts();
			end
		end
		quiet_sender = 1'b0;
	endtask

	// result sink with random stalls and stall-free stretches
	always @(negedge clk) begin
		int r;
		if (sink_quiet > 0) begin
			sink_quiet--;
			res_ch.ready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold--;
			res_ch.ready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				sink_quiet = $urandom_range(20, 80);
				res_ch.ready <= 1'b1;
			end else if (r < 70) begin
				res_ch.ready <= 1'b1;
			end else if (r < 95) begin
				sink_hold = $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				sink_hold = $urandom_range(10, 30);
				res_ch.ready <= 1'b0;
			end
		end
	end

	// compare each verdict with the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict matched=%b overflow=%b",
					$time, res_ch.matched, res_ch.pattern_overflow);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (res_ch.matched !== want.matched) begin
					$display("%0t: matched expected %b actual %b",
						$time, want.matched, res_ch.matched);
					errors++;
				end
				if (res_ch.pattern_overflow !== want.overflow) begin
					$display("%0t: pattern_overflow expected %b actual %b",
						$time, want.overflow, res_ch.pattern_overflow);
					errors++;
				end
			end
		end
	end

	// reset, test sequence and final verdict
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = wpm_pkg::CMD_APPEND;
		req_ch.symbol = 8'h00;
		res_ch.ready = 1'b0;
		quiet_sender = 1'b0;
		items_sent = 0;
		errors = 0;
		pattern_len = 0;
		overflow_seen = 1'b0;
		reload_row();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_pattern();
		test_literals_and_any();
		test_star_against_star();
		wait_for_verdicts();
		test_full_pattern();
		test_random_sequences();

		wait_for_verdicts();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
